FILE: hdl/sapf_pkg.sv
// Package: types, constants and sequencer states for the second-order allpass filter unit.
`timescale 1ns / 1ps

package sapf_pkg;

    localparam int CHANNELS    = 8;
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SAMPLE_BITS = 24;
    localparam int CHAN_BITS   = 3;
    localparam int COEF1_BITS  = 24;
    localparam int COEF2_BITS  = 23;
    localparam int COEF_FRAC   = 22;
    localparam int OP_W        = SAMPLE_BITS + 1;
    localparam int PROD_W      = 2 * OP_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_FIRST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_SECOND = CFG_IDX_W'(1);

    localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO   = -SAT_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< (COEF_FRAC - 1));

    typedef struct packed {
        logic [CHAN_BITS-1:0]          chan;
        logic signed [SAMPLE_BITS-1:0] sample_in;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_BITS-1:0]          chan_out;
        logic signed [SAMPLE_BITS-1:0] sample_out;
    } t_out_item;

    typedef struct packed {
        logic en;
        logic load;
    } t_mac_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC1,
        ST_MAC2,
        ST_FIN
    } t_state;

endpackage

FILE: hdl/sapf_mac.sv
// Shared multiply-accumulate unit used by the allpass sequencer.
`timescale 1ns / 1ps

module sapf_mac (
    input  logic                                i_clk,
    input  sapf_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [sapf_pkg::ACC_W-1:0]   i_init,
    input  logic signed [sapf_pkg::OP_W-1:0]    i_op_a,
    input  logic signed [sapf_pkg::OP_W-1:0]    i_op_b,
    output logic signed [sapf_pkg::ACC_W-1:0]   o_acc
);
    import sapf_pkg::*;

    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;

    assign prod  = i_op_a * i_op_b;
    assign base  = i_ctl.load ? i_init : r_acc;
    assign n_acc = base + ACC_W'(prod);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

FILE: hdl/second_order_allpass_filter_unit.sv
// Top level: multichannel second-order allpass filter with a shared multiply-accumulate unit.
//
//  channel | handshake                | payload
//  --------+--------------------------+---------------------------------
//  in      | i_in_valid / o_in_ready  | i_in  (chan, sample_in)
//  out     | o_out_valid / i_out_ready| o_out (chan_out, sample_out)
//  cfg     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// An item makes three passes through the one multiply-accumulate unit
// (a2*x, a1*(x1-y1), -a2*y2), then round, saturate and history update.
// The next item is taken the cycle after the update, not while one is in progress.
// A held result stalls the update cycle only while the output register is still full.
// Synchronous reset clears coefficients, all channel histories and the sequencer.
`timescale 1ns / 1ps

module second_order_allpass_filter_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  sapf_pkg::t_in_item                     i_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output sapf_pkg::t_out_item                    o_out,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [sapf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [sapf_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import sapf_pkg::*;

    logic signed [COEF1_BITS-1:0]  r_coef1;
    logic [COEF2_BITS-1:0]         r_coef2;

    logic signed [SAMPLE_BITS-1:0] r_in1  [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_in2  [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_out1 [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_out2 [CHANNELS];

    t_state r_state;
    t_state n_state;

    logic [CHAN_BITS-1:0]          r_chan;
    logic                          r_chan_ok;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_x1;
    logic signed [SAMPLE_BITS-1:0] r_y1;
    logic signed [OP_W-1:0]        r_diff;
    logic signed [OP_W-1:0]        r_neg_y2;

    logic                          r_out_valid;
    t_out_item                     r_out;

    logic                          in_fire;
    logic                          fin_go;
    logic [CH_W-1:0]               in_idx;
    logic [CH_W-1:0]               wr_idx;
    logic                          in_chan_ok;

    t_mac_ctl                      mac_ctl;
    logic signed [ACC_W-1:0]       mac_init;
    logic signed [OP_W-1:0]        mac_a;
    logic signed [OP_W-1:0]        mac_b;
    logic signed [ACC_W-1:0]       acc;
    logic signed [ACC_W-1:0]       acc_shift;
    logic signed [SAMPLE_BITS-1:0] y_sat;

    logic signed [OP_W-1:0]        coef1_op;
    logic signed [OP_W-1:0]        coef2_op;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign fin_go      = (r_state == ST_FIN) && (!r_out_valid || i_out_ready);
    assign in_idx      = i_in.chan[CH_W-1:0];
    assign wr_idx      = r_chan[CH_W-1:0];
    assign in_chan_ok  = (32'(i_in.chan) < CHANNELS);

    assign coef1_op = OP_W'(r_coef1);
    assign coef2_op = OP_W'(signed'({1'b0, r_coef2}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef1 <= '0;
            r_coef2 <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_COEF_FIRST:  r_coef1 <= i_cfg_data[COEF1_BITS-1:0];
                CFG_COEF_SECOND: r_coef2 <= i_cfg_data[COEF2_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_fire) n_state = ST_MAC1;
            ST_MAC1: n_state = ST_MAC2;
            ST_MAC2: n_state = ST_FIN;
            ST_FIN:  if (fin_go) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        mac_ctl  = '0;
        mac_init = '0;
        mac_a    = coef2_op;
        mac_b    = r_neg_y2;
        unique case (r_state)
            ST_IDLE: begin
                mac_ctl.en   = in_fire;
                mac_ctl.load = 1'b1;
                mac_init     = (ACC_W'(r_in2[in_idx]) <<< COEF_FRAC) + ROUND_HALF;
                mac_a        = coef2_op;
                mac_b        = OP_W'(i_in.sample_in);
            end
            ST_MAC1: begin
                mac_ctl.en = 1'b1;
                mac_a      = coef1_op;
                mac_b      = r_diff;
            end
            ST_MAC2: begin
                mac_ctl.en = 1'b1;
                mac_a      = coef2_op;
                mac_b      = r_neg_y2;
            end
            ST_FIN: begin
                mac_ctl = '0;
            end
            default: mac_ctl = '0;
        endcase
    end

    sapf_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_init (mac_init),
        .i_op_a (mac_a),
        .i_op_b (mac_b),
        .o_acc  (acc)
    );

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_chan    <= i_in.chan;
            r_chan_ok <= in_chan_ok;
            r_x       <= i_in.sample_in;
            r_x1      <= r_in1[in_idx];
            r_y1      <= r_out1[in_idx];
            r_diff    <= OP_W'(r_in1[in_idx]) - OP_W'(r_out1[in_idx]);
            r_neg_y2  <= -OP_W'(r_out2[in_idx]);
        end
    end

    assign acc_shift = acc >>> COEF_FRAC;

    always_comb begin
        priority if (acc_shift > SAT_HI) begin
            y_sat = SAT_HI[SAMPLE_BITS-1:0];
        end else if (acc_shift < SAT_LO) begin
            y_sat = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            y_sat = acc_shift[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_in1[k]  <= '0;
                r_in2[k]  <= '0;
                r_out1[k] <= '0;
                r_out2[k] <= '0;
            end
        end else if (fin_go && r_chan_ok) begin
            r_in2[wr_idx]  <= r_x1;
            r_out2[wr_idx] <= r_y1;
            r_in1[wr_idx]  <= r_x;
            r_out1[wr_idx] <= y_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_out.chan_out   <= r_chan;
            r_out.sample_out <= r_chan_ok ? y_sat : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    a_accept_starts_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_MAC1))
        else $error("accepted item did not start the multiply sequence");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_FIN))
        else $error("result appeared without a finish cycle");

    a_fin_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_go |=> (o_out_valid && (r_state == ST_IDLE)))
        else $error("finish cycle did not load the output register");
`endif

endmodule
